// File: sv/drh_pkg.sv
`timescale 1ns / 1ps
// shared types and constants for the distance response hermite block
// no dependencies

package drh_pkg;

  localparam int unsigned FRAC_BITS_DEFAULT = 16;

  localparam int unsigned DIST_W     = 32;
  localparam int unsigned MAXD_W     = 24;
  localparam int unsigned BLEND_W    = 23;
  localparam int unsigned FORCE_W    = 24;
  localparam int unsigned RESP_W     = 32;
  localparam int unsigned DIV_W      = 24;
  localparam int unsigned SLOPE_W    = 36;
  localparam int unsigned FIFO_DEPTH = 2;

  localparam int unsigned CFG_INDEX_W = 2;
  localparam int unsigned CFG_DATA_W  = 24;

  localparam logic [MAXD_W-1:0]  MAXD_RESET  = 24'd131072;
  localparam logic [BLEND_W-1:0] BLEND_RESET = 23'd6554;
  localparam logic [FORCE_W-1:0] FORCE_RESET = 24'd196608;

  localparam logic [SLOPE_W-1:0] SLOPE_CAP = '1;
  localparam logic [RESP_W-1:0]  RESP_MAX  = '1;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_MAX_DISTANCE = 2'd0,
    CFG_BLEND_WIDTH  = 2'd1,
    CFG_PEAK_FORCE   = 2'd2
  } drh_cfg_idx_e;

  typedef enum logic [2:0] {
    REG_ZERO    = 3'd0,
    REG_CONTACT = 3'd1,
    REG_UPPER   = 3'd2,
    REG_MIDDLE  = 3'd3,
    REG_LOWER   = 3'd4
  } drh_region_e;

  typedef struct packed {
    logic [MAXD_W-1:0]  max_distance;
    logic [BLEND_W-1:0] blend_width;
    logic [FORCE_W-1:0] peak_force;
  } drh_cfg_t;

  typedef struct packed {
    drh_region_e        region;
    logic [DIV_W-1:0]   divisor;
    logic               recip_sat;
    logic [BLEND_W-1:0] offset;
  } drh_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } drh_fifo_status_t;

endpackage

// File: sv/drh_front.sv
`timescale 1ns / 1ps
// front stage: accepts distance items, picks the curve region and the divider operands
// depends on drh_pkg

module drh_front (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  drh_pkg::drh_cfg_t              cfg_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic signed [drh_pkg::DIST_W-1:0] effective_distance_i,
  input  drh_pkg::drh_fifo_status_t      fifo_status_i,
  output logic                           push_o,
  output drh_pkg::drh_entry_t            entry_o
);
  import drh_pkg::*;

  logic              valid_q;
  drh_entry_t        entry_q, entry_d;
  logic              accept;
  logic signed [DIST_W:0] distance, maxd, width, start, diff;

  assign distance = {effective_distance_i[DIST_W-1], effective_distance_i};
  assign maxd     = {{(DIST_W+1-MAXD_W){1'b0}}, cfg_i.max_distance};
  assign width    = {{(DIST_W+1-BLEND_W){1'b0}}, cfg_i.blend_width};
  assign start    = maxd - width;
  assign diff     = distance - start;

  always_comb begin
    entry_d.region    = REG_ZERO;
    entry_d.divisor   = DIV_W'(1);
    entry_d.recip_sat = 1'b0;
    entry_d.offset    = '0;
    if (distance >= maxd) begin
      entry_d.region = REG_ZERO;
    end else if (distance <= 33'sd0) begin
      entry_d.region = REG_CONTACT;
    end else if (distance > start) begin
      entry_d.region    = REG_UPPER;
      entry_d.divisor   = start[DIV_W-1:0];
      entry_d.recip_sat = (start <= 33'sd0);
      entry_d.offset    = diff[BLEND_W-1:0];
    end else if (distance > width) begin
      entry_d.region  = REG_MIDDLE;
      entry_d.divisor = distance[DIV_W-1:0];
    end else begin
      entry_d.region  = REG_LOWER;
      entry_d.divisor = {1'b0, cfg_i.blend_width};
      entry_d.offset  = distance[BLEND_W-1:0];
    end
  end

  assign push_o     = valid_q && !fifo_status_i.full;
  assign in_stall_o = valid_q && fifo_status_i.full;
  assign accept     = in_valid_i && !in_stall_o;
  assign entry_o    = entry_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (accept) begin
      valid_q <= 1'b1;
    end else if (push_o) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      entry_q <= entry_d;
    end
  end

endmodule

// File: sv/drh_fifo.sv
`timescale 1ns / 1ps
// short queue of classified items between front and back
// depends on drh_pkg

module drh_fifo (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      push_i,
  input  drh_pkg::drh_entry_t       entry_i,
  input  logic                      pop_i,
  output drh_pkg::drh_entry_t       entry_o,
  output drh_pkg::drh_fifo_status_t status_o
);
  import drh_pkg::*;

  localparam int unsigned PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(FIFO_DEPTH + 1);

  drh_entry_t       slots_q [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] count_q;

  function automatic logic [PTR_W-1:0] next_ptr(logic [PTR_W-1:0] p);
    next_ptr = (p == PTR_W'(FIFO_DEPTH - 1)) ? '0 : PTR_W'(p + 1'b1);
  endfunction

  assign entry_o        = slots_q[rd_ptr_q];
  assign status_o.full  = (count_q == CNT_W'(FIFO_DEPTH));
  assign status_o.empty = (count_q == '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= next_ptr(wr_ptr_q);
      end
      if (pop_i) begin
        rd_ptr_q <= next_ptr(rd_ptr_q);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slots_q[wr_ptr_q] <= entry_i;
    end
  end

endmodule

// File: sv/drh_back.sv
`timescale 1ns / 1ps
// back pipeline: bit-per-stage dividers, hermite basis, products, sum and clamp
// depends on drh_pkg

module drh_back #(
  parameter int unsigned FRAC_BITS = drh_pkg::FRAC_BITS_DEFAULT
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  drh_pkg::drh_cfg_t            cfg_i,
  input  logic                         fifo_valid_i,
  input  drh_pkg::drh_entry_t          entry_i,
  output logic                         pop_o,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [drh_pkg::RESP_W-1:0]   response_o
);
  import drh_pkg::*;

  localparam int unsigned F       = FRAC_BITS;
  localparam int unsigned UW      = F + 1;
  localparam int unsigned QW      = (2 * F + 1 > RESP_W + 1) ? 2 * F + 1 : RESP_W + 1;
  localparam int unsigned ONE_POS = QW - 1 - 2 * F;
  localparam int unsigned HW      = F + 4;
  localparam int unsigned HM      = F + 3;
  localparam int unsigned AW      = RESP_W + HM - F;
  localparam int unsigned M1W     = SLOPE_W + HM - F;
  localparam int unsigned CW      = M1W + BLEND_W - F;
  localparam int unsigned SW      = ((AW > CW) ? AW : CW) + 3;

  typedef struct packed {
    drh_region_e        region;
    logic [DIV_W-1:0]   divisor;
    logic               recip_sat;
    logic [DIV_W-1:0]   rrem;
    logic [QW-1:0]      rq;
    logic [BLEND_W-1:0] urem;
    logic [UW-1:0]      uq;
  } stage_t;

  function automatic logic [HM-1:0] mag_of(logic signed [HW-1:0] h);
    mag_of = h[HW-1] ? HM'(-h) : h[HM-1:0];
  endfunction

  logic en;
  logic [FORCE_W+1:0] pf3;

  assign en    = !(out_valid_o && out_stall_i);
  assign pop_o = en && fifo_valid_i;
  assign pf3   = {2'b00, cfg_i.peak_force} + {1'b0, cfg_i.peak_force, 1'b0};

  // divider stages
  stage_t st_q   [QW];
  logic   st_v_q [QW];

  for (genvar k = 0; k < QW; k++) begin : g_div
    stage_t             prev, nxt;
    logic               prev_v, rbit, ubit;
    logic [DIV_W:0]     rtrial;
    logic [BLEND_W:0]   utrial;

    if (k == 0) begin : g_first
      assign prev.region    = entry_i.region;
      assign prev.divisor   = entry_i.divisor;
      assign prev.recip_sat = entry_i.recip_sat;
      assign prev.rrem      = '0;
      assign prev.rq        = '0;
      assign prev.urem      = {1'b0, entry_i.offset[BLEND_W-1:1]};
      assign prev.uq        = '0;
      assign ubit           = entry_i.offset[0];
      assign prev_v         = fifo_valid_i;
    end else begin : g_rest
      assign prev   = st_q[k-1];
      assign ubit   = 1'b0;
      assign prev_v = st_v_q[k-1];
    end

    assign rbit = (k == ONE_POS) ? 1'b1 : 1'b0;

    always_comb begin
      nxt    = prev;
      rtrial = {prev.rrem, rbit};
      if (rtrial >= {1'b0, prev.divisor}) begin
        nxt.rrem = DIV_W'(rtrial - {1'b0, prev.divisor});
        nxt.rq   = {prev.rq[QW-2:0], 1'b1};
      end else begin
        nxt.rrem = rtrial[DIV_W-1:0];
        nxt.rq   = {prev.rq[QW-2:0], 1'b0};
      end
      utrial = {prev.urem, ubit};
      if (k < UW) begin
        if (utrial >= {1'b0, cfg_i.blend_width}) begin
          nxt.urem = BLEND_W'(utrial - {1'b0, cfg_i.blend_width});
          nxt.uq   = {prev.uq[UW-2:0], 1'b1};
        end else begin
          nxt.urem = utrial[BLEND_W-1:0];
          nxt.uq   = {prev.uq[UW-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        st_v_q[k] <= 1'b0;
      end else if (en) begin
        st_v_q[k] <= prev_v;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        st_q[k] <= nxt;
      end
    end
  end

  // stage 1: reciprocal saturation, u^2, slope
  stage_t                 last;
  logic [RESP_W-1:0]      f_d;
  logic [2*RESP_W-1:0]    f_sq, f_sq_sh;
  logic [SLOPE_W-1:0]     s_d;
  logic [2*UW-1:0]        u_sq;

  assign last    = st_q[QW-1];
  assign f_d     = (last.recip_sat || (last.rq > QW'(RESP_MAX))) ? RESP_MAX
                                                                : last.rq[RESP_W-1:0];
  assign f_sq    = (2*RESP_W)'(f_d) * (2*RESP_W)'(f_d);
  assign f_sq_sh = f_sq >> F;
  assign s_d     = (f_sq_sh > (2*RESP_W)'(SLOPE_CAP)) ? SLOPE_CAP : f_sq_sh[SLOPE_W-1:0];
  assign u_sq    = (2*UW)'(last.uq) * (2*UW)'(last.uq);

  logic               s1_v_q;
  drh_region_e        s1_region_q;
  logic [RESP_W-1:0]  s1_f_q;
  logic [UW-1:0]      s1_u_q, s1_u2_q;
  logic [SLOPE_W-1:0] s1_s_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_region_q <= last.region;
      s1_f_q      <= f_d;
      s1_u_q      <= last.uq;
      s1_u2_q     <= UW'(u_sq >> F);
      s1_s_q      <= s_d;
    end
  end

  // stage 2: u^3
  logic [2*UW-1:0]    u_cu;
  assign u_cu = (2*UW)'(s1_u2_q) * (2*UW)'(s1_u_q);

  logic               s2_v_q;
  drh_region_e        s2_region_q;
  logic [RESP_W-1:0]  s2_f_q;
  logic [UW-1:0]      s2_u_q, s2_u2_q, s2_u3_q;
  logic [SLOPE_W-1:0] s2_s_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      s2_region_q <= s1_region_q;
      s2_f_q      <= s1_f_q;
      s2_u_q      <= s1_u_q;
      s2_u2_q     <= s1_u2_q;
      s2_u3_q     <= UW'(u_cu >> F);
      s2_s_q      <= s1_s_q;
    end
  end

  // stage 3: hermite basis
  logic signed [HW-1:0] eu, eu2, eu3, one_h, h1_d, h2_d, hc_d;

  assign eu    = {3'b000, s2_u_q};
  assign eu2   = {3'b000, s2_u2_q};
  assign eu3   = {3'b000, s2_u3_q};
  assign one_h = {{(HW-1-F){1'b0}}, 1'b1, {F{1'b0}}};
  assign h1_d  = (eu3 <<< 1) - (eu2 <<< 1) - eu2 + one_h;
  assign h2_d  = (eu2 <<< 1) + eu2 - (eu3 <<< 1);
  assign hc_d  = (s2_region_q == REG_UPPER) ? (eu3 - (eu2 <<< 1) + eu) : (eu3 - eu2);

  logic                 s3_v_q;
  drh_region_e          s3_region_q;
  logic [RESP_W-1:0]    s3_f_q;
  logic [SLOPE_W-1:0]   s3_s_q;
  logic signed [HW-1:0] s3_h1_q, s3_h2_q, s3_hc_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      s3_region_q <= s2_region_q;
      s3_f_q      <= s2_f_q;
      s3_s_q      <= s2_s_q;
      s3_h1_q     <= h1_d;
      s3_h2_q     <= h2_d;
      s3_hc_q     <= hc_d;
    end
  end

  // stage 4: value products and slope times basis
  logic [RESP_W-1:0]      y1, y2;
  logic [RESP_W+HM-1:0]   a_prod, b_prod;
  logic [AW-1:0]          a_mag, b_mag;
  logic signed [AW:0]     a_d, b_d;
  logic [SLOPE_W+HM-1:0]  m_prod;

  assign y1     = (s3_region_q == REG_UPPER) ? s3_f_q : RESP_W'(pf3);
  assign y2     = (s3_region_q == REG_LOWER) ? s3_f_q : '0;
  assign a_prod = (RESP_W+HM)'(y1) * (RESP_W+HM)'(mag_of(s3_h1_q));
  assign b_prod = (RESP_W+HM)'(y2) * (RESP_W+HM)'(mag_of(s3_h2_q));
  assign a_mag  = AW'(a_prod >> F);
  assign b_mag  = AW'(b_prod >> F);
  assign a_d    = s3_h1_q[HW-1] ? -$signed({1'b0, a_mag}) : $signed({1'b0, a_mag});
  assign b_d    = s3_h2_q[HW-1] ? -$signed({1'b0, b_mag}) : $signed({1'b0, b_mag});
  assign m_prod = (SLOPE_W+HM)'(s3_s_q) * (SLOPE_W+HM)'(mag_of(s3_hc_q));

  logic               s4_v_q;
  drh_region_e        s4_region_q;
  logic [RESP_W-1:0]  s4_f_q;
  logic signed [AW:0] s4_a_q, s4_b_q;
  logic [M1W-1:0]     s4_m1_q;
  logic               s4_cpos_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      s4_region_q <= s3_region_q;
      s4_f_q      <= s3_f_q;
      s4_a_q      <= a_d;
      s4_b_q      <= b_d;
      s4_m1_q     <= M1W'(m_prod >> F);
      s4_cpos_q   <= s3_hc_q[HW-1];
    end
  end

  // stage 5: slope term times band width
  logic [M1W+BLEND_W-1:0] c_prod;
  logic [CW-1:0]          c_mag;
  logic signed [CW:0]     c_d;

  assign c_prod = (M1W+BLEND_W)'(s4_m1_q) * (M1W+BLEND_W)'(cfg_i.blend_width);
  assign c_mag  = CW'(c_prod >> F);
  assign c_d    = s4_cpos_q ? $signed({1'b0, c_mag}) : -$signed({1'b0, c_mag});

  logic               s5_v_q;
  drh_region_e        s5_region_q;
  logic [RESP_W-1:0]  s5_f_q;
  logic signed [AW:0] s5_a_q, s5_b_q;
  logic signed [CW:0] s5_c_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      s5_region_q <= s4_region_q;
      s5_f_q      <= s4_f_q;
      s5_a_q      <= s4_a_q;
      s5_b_q      <= s4_b_q;
      s5_c_q      <= c_d;
    end
  end

  // output register: sum, clamp, region select
  logic signed [SW-1:0] sum;
  logic [RESP_W-1:0]    blend_r, resp_d, response_q;
  logic                 out_valid_q;

  assign sum     = SW'(s5_a_q) + SW'(s5_b_q) + SW'(s5_c_q);
  assign blend_r = sum[SW-1] ? '0
                 : (|sum[SW-2:RESP_W]) ? RESP_MAX : sum[RESP_W-1:0];

  always_comb begin
    case (s5_region_q)
      REG_ZERO:    resp_d = '0;
      REG_CONTACT: resp_d = RESP_W'(pf3);
      REG_MIDDLE:  resp_d = s5_f_q;
      REG_UPPER:   resp_d = blend_r;
      REG_LOWER:   resp_d = blend_r;
      default:     resp_d = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q      <= 1'b0;
      s2_v_q      <= 1'b0;
      s3_v_q      <= 1'b0;
      s4_v_q      <= 1'b0;
      s5_v_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      s1_v_q      <= st_v_q[QW-1];
      s2_v_q      <= s1_v_q;
      s3_v_q      <= s2_v_q;
      s4_v_q      <= s3_v_q;
      s5_v_q      <= s4_v_q;
      out_valid_q <= s5_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      response_q <= resp_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign response_o  = response_q;

endmodule

// File: sv/distance_response_hermite.sv
`timescale 1ns / 1ps
// top level of the distance response hermite block: config registers, front, queue, back
// depends on drh_pkg, drh_front, drh_fifo, drh_back

// Maps a signed effective distance to a saturating unsigned repulsion response along a
// piecewise curve: zero at or beyond max_distance, three times peak_force at or below zero,
// 1/distance in the middle, and cubic hermite blends in the bands of blend_width at both ends.
// One item is taken per clock while in_stall_o is low. The reciprocal divider resolves one
// quotient bit per pipeline stage. A two-entry queue sits between the classifying front
// stage and the arithmetic back pipeline, and the back pipeline holds as a whole while its
// output waits. Registers are written through the cfg port, always ready; the user must
// write them only while no item is in flight, as the block itself does not enforce it.

module distance_response_hermite #(
  parameter int unsigned FRAC_BITS = drh_pkg::FRAC_BITS_DEFAULT
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [drh_pkg::CFG_INDEX_W-1:0]   cfg_index_i,
  input  logic [drh_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic signed [drh_pkg::DIST_W-1:0] effective_distance_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [drh_pkg::RESP_W-1:0]        response_o
);
  import drh_pkg::*;

  drh_cfg_t         cfg_q;
  drh_entry_t       front_entry, fifo_entry;
  drh_fifo_status_t fifo_status;
  logic             push, pop;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.max_distance <= MAXD_RESET;
      cfg_q.blend_width  <= BLEND_RESET;
      cfg_q.peak_force   <= FORCE_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (drh_cfg_idx_e'(cfg_index_i))
        CFG_MAX_DISTANCE: cfg_q.max_distance <= cfg_data_i[MAXD_W-1:0];
        CFG_BLEND_WIDTH:  cfg_q.blend_width  <= cfg_data_i[BLEND_W-1:0];
        CFG_PEAK_FORCE:   cfg_q.peak_force   <= cfg_data_i[FORCE_W-1:0];
        default: ;
      endcase
    end
  end

  drh_front u_front (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .cfg_i                (cfg_q),
    .in_valid_i           (in_valid_i),
    .in_stall_o           (in_stall_o),
    .effective_distance_i (effective_distance_i),
    .fifo_status_i        (fifo_status),
    .push_o               (push),
    .entry_o              (front_entry)
  );

  drh_fifo u_fifo (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .entry_i  (front_entry),
    .pop_i    (pop),
    .entry_o  (fifo_entry),
    .status_o (fifo_status)
  );

  drh_back #(
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .fifo_valid_i (!fifo_status.empty),
    .entry_i      (fifo_entry),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .response_o   (response_o)
  );

  a_no_push_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> !fifo_status.full)
    else $error("queue written while full");

  a_no_pop_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !fifo_status.empty)
    else $error("queue read while empty");

  a_accept_reaches_front: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> (push || in_stall_o))
    else $error("accepted item lost in front stage");

endmodule

// File: tb/sv/tb.sv
`timescale 1ns / 1ps
// testbench for distance_response_hermite: random and directed distances, checked against
// an in-bench fixed point model of the response curve through a small scoreboard class
// depends on drh_pkg and distance_response_hermite

module tb;
  import drh_pkg::*;

  localparam int unsigned FB = FRAC_BITS_DEFAULT;
  localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_IDX = 2'd3;
  localparam longint unsigned SAT32 = 64'hFFFF_FFFF;
  localparam longint SLOPE_MAX = (64'sd1 <<< 36) - 1;
  localparam int DRAIN_CYCLES = 60;
  localparam longint CYCLE_LIMIT = 400000;

  class response_board;
    longint maxd, bw, pf;
    longint unsigned pending[$];
    int errors;

    function new();
      maxd = MAXD_RESET; bw = BLEND_RESET; pf = FORCE_RESET; errors = 0;
    endfunction

    function longint fmul(longint a, longint b);
      longint unsigned ua, ub, p;
      ua = (a < 0) ? -a : a;
      ub = (b < 0) ? -b : b;
      p = (ua * ub) >> FB;
      return ((a < 0) != (b < 0)) ? -longint'(p) : longint'(p);
    endfunction

    function longint recip(longint x);
      longint unsigned q;
      if (x <= 0) return SAT32;
      q = (64'd1 << (2 * FB)) / x;
      return (q > SAT32) ? SAT32 : q;
    endfunction

    function longint slope_of(longint f);
      longint unsigned s;
      s = (longint'(f) * longint'(f)) >> FB;
      if (s > SLOPE_MAX) s = SLOPE_MAX;
      return -longint'(s);
    endfunction

    function longint unsigned clamp(longint v);
      if (v < 0) return 0;
      if (v > SAT32) return SAT32;
      return v;
    endfunction

    function longint hermite(longint d, longint x1, longint sc, longint y1, longint y2,
                             longint dy1, longint dy2);
      longint u, u2, u3, one;
      u = longint'((unsigned'(d - x1) << FB) / unsigned'(sc));
      one = 64'sd1 <<< FB;
      u2 = fmul(u, u);
      u3 = fmul(u2, u);
      return fmul(y1, 2 * u3 - 3 * u2 + one) + fmul(y2, -2 * u3 + 3 * u2)
           + fmul(fmul(dy1, u3 - 2 * u2 + u), sc) + fmul(fmul(dy2, u3 - u2), sc);
    endfunction

    function longint unsigned response_of(logic signed [DIST_W-1:0] distance);
      longint d, start, f, pf3;
      d = distance;
      pf3 = 3 * pf;
      start = maxd - bw;
      if (d >= maxd) return 0;
      if (d <= 0) return clamp(pf3);
      if (d > start) begin
        f = recip(start);
        return clamp(hermite(d, start, bw, f, 0, slope_of(f), 0));
      end
      if (d > bw) return clamp(recip(d));
      f = recip(bw);
      return clamp(hermite(d, 0, bw, pf3, f, 0, slope_of(f)));
    endfunction

    function void set_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_MAX_DISTANCE: maxd = data;
        CFG_BLEND_WIDTH:  bw = data[BLEND_W-1:0];
        CFG_PEAK_FORCE:   pf = data;
        default: ;
      endcase
    endfunction

    function void note_item(logic signed [DIST_W-1:0] distance);
      pending.push_back(response_of(distance));
    endfunction

    task report(string msg);
      $display("mismatch: %s", msg);
      errors++;
    endtask

    task check_item(logic [RESP_W-1:0] resp);
      longint unsigned exp_r;
      if (pending.size() == 0) begin
        report($sformatf("unexpected response %h", resp));
        return;
      end
      exp_r = pending.pop_front();
      if (resp !== exp_r[RESP_W-1:0])
        report($sformatf("response %h, expected %h", resp, exp_r[RESP_W-1:0]));
    endtask
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [CFG_INDEX_W-1:0] cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic signed [DIST_W-1:0] effective_distance_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [RESP_W-1:0] response_o;

  int send_pct = 0;
  int recv_pct = 0;
  longint cycles = 0;
  response_board board = new();

  distance_response_hermite dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && !in_stall_o) board.note_item(effective_distance_i);
    if (rst_ni && out_valid_o && !out_stall_i) board.check_item(response_o);
  end

  always @(negedge clk_i) out_stall_i <= ($urandom_range(99) < recv_pct);

  task send_dist(logic signed [DIST_W-1:0] distance);
    while ($urandom_range(99) < send_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    effective_distance_i <= distance;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
  endtask

  task write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    board.set_reg(idx, data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task drain;
    in_valid_i <= 1'b0;
    while (board.pending.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  function automatic logic signed [DIST_W-1:0] pick_dist();
    longint m, w, v;
    m = board.maxd;
    w = board.bw;
    case ($urandom_range(9))
      0: v = $urandom();
      1: v = -longint'($urandom_range(1000));
      2: v = m + $urandom_range(3) - 1;
      3: v = m - w + $urandom_range(4) - 2;
      4: v = w + $urandom_range(4) - 2;
      5: v = m + $urandom_range(100000);
      6: v = (w > 0) ? $urandom_range(w) : 1;
      7: v = (w > 0 && m > w) ? m - $urandom_range(w) : m - 1;
      default: v = $urandom_range(m > 0 ? m : 1);
    endcase
    return v[DIST_W-1:0];
  endfunction

  task run_phase(int items);
    repeat (items) send_dist(pick_dist());
    drain();
  endtask

  initial begin
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    send_pct = 23; recv_pct = 73;
    // directed: extremes and region boundaries at reset settings
    send_dist(32'sh7FFF_FFFF);
    send_dist(32'sh8000_0000);
    send_dist(32'sd0);
    send_dist(-32'sd1);
    send_dist(32'sd1);
    send_dist(32'sd6553);
    send_dist(32'sd6554);
    send_dist(32'sd6555);
    send_dist(32'sd65536);
    send_dist(32'sd124517);
    send_dist(32'sd124518);
    send_dist(32'sd124519);
    send_dist(32'sd131071);
    send_dist(32'sd131072);
    send_dist(32'sd131073);
    send_dist(32'sh5555_5555);
    send_dist(32'shAAAA_AAAA);
    run_phase(110);
    write_reg(CFG_MAX_DISTANCE, 24'hFFFFFF);
    write_reg(CFG_BLEND_WIDTH, 24'h7FFFFF);
    write_reg(CFG_PEAK_FORCE, 24'hFFFFFF);
    run_phase(130);
    send_pct = 73; recv_pct = 23;
    // band start not positive
    write_reg(CFG_MAX_DISTANCE, 24'd1);
    write_reg(CFG_BLEND_WIDTH, 24'd1);
    write_reg(CFG_PEAK_FORCE, 24'd0);
    run_phase(100);
    // zero blend width, and the spare index is ignored
    write_reg(CFG_MAX_DISTANCE, 24'd65536);
    write_reg(CFG_BLEND_WIDTH, 24'd0);
    write_reg(CFG_PEAK_FORCE, 24'd100);
    write_reg(CFG_SPARE_IDX, 24'hABCDEF);
    run_phase(120);
    send_pct = 0; recv_pct = 0;
    // wider bands that still leave a middle region between them
    write_reg(CFG_MAX_DISTANCE, 24'd131072);
    write_reg(CFG_BLEND_WIDTH, 24'd40000);
    write_reg(CFG_PEAK_FORCE, 24'd12345);
    run_phase(110);
    repeat (4) begin
      write_reg(CFG_MAX_DISTANCE, $urandom_range(24'hFFFFFF, 1));
      write_reg(CFG_BLEND_WIDTH, $urandom_range(board.maxd / 2, 0));
      write_reg(CFG_PEAK_FORCE, $urandom_range(24'hFFFFFF));
      run_phase(60);
    end
    if (board.errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule

// File: files.f
sv/drh_pkg.sv
sv/drh_front.sv
sv/drh_fifo.sv
sv/drh_back.sv
sv/distance_response_hermite.sv
tb/sv/tb.sv
